// ----- rtl/core/oahi_pkg.sv -----
package oahi_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = ADDR_W + 1;

   // field widths
   localparam int KEY_W    = 31;
   localparam int SIZE_W   = 11;
   localparam int MODE_W   = 2;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 10;
   localparam int PROBES_W = 11;

   localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(TABLE_DEPTH);

   // remainder unit: one dividend bit per cycle
   localparam int DIV_CNT_W = $clog2(KEY_W);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(KEY_W - 1);

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_DEPTH - 1);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_SCAN_CHK,
      S_DIV,
      S_PROBE,
      S_PROBE_CHK
   } state_type;

   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_LIMIT = 2'd2;

   localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd0;
   localparam logic [MODE_W-1:0] MODE_QUAD   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DOUBLE = 2'd2;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   localparam logic CSR_TABLE_SIZE = 1'b0;
   localparam logic CSR_PROBE_MODE = 1'b1;

   // (a + b) mod m, with a, b < m
   function automatic logic [ADDR_W-1:0] add_mod(input logic [ADDR_W-1:0] a,
                                                 input logic [ADDR_W-1:0] b,
                                                 input logic [SIZE_W-1:0] m);
      logic [CNT_W-1:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= CNT_W'(m)) begin
         sum = sum - CNT_W'(m);
      end
      return sum[ADDR_W-1:0];
   endfunction

   // (d + 2) mod m, with d < m; m may be 1
   function automatic logic [ADDR_W-1:0] add2_mod(input logic [ADDR_W-1:0] d,
                                                  input logic [SIZE_W-1:0] m);
      logic [CNT_W-1:0] sum;
      sum = {1'b0, d} + CNT_W'(2);
      if (sum >= CNT_W'(m)) begin
         sum = sum - CNT_W'(m);
      end
      if (sum >= CNT_W'(m)) begin
         sum = sum - CNT_W'(m);
      end
      return sum[ADDR_W-1:0];
   endfunction

endpackage

// ----- rtl/core/oahi_rem.sv -----
// Restoring remainder: dividend mod divisor, one bit per cycle.
module oahi_rem import oahi_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [KEY_W-1:0]    dividend,
   input  logic [SIZE_W-1:0]   divisor,
   output logic                done,
   output logic [ADDR_W-1:0]   remainder
);

   logic                 busy_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 done_ff;
   logic [KEY_W-1:0]     dvd_ff;
   logic [ADDR_W-1:0]    rem_ff;
   logic [ADDR_W-1:0]    rem_in;
   logic [SIZE_W-1:0]    shifted;

   always_comb begin
      shifted = {rem_ff, dvd_ff[KEY_W-1]};
      if (shifted >= divisor) begin
         rem_in = ADDR_W'(shifted - divisor);
      end else begin
         rem_in = shifted[ADDR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == DIV_LAST);
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            if (cnt_ff == DIV_LAST) begin
               busy_ff <= 1'b0;
            end
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         rem_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[KEY_W-2:0], 1'b0};
         rem_ff <= rem_in;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ----- rtl/core/open_addressing_hash_insert.sv -----
// Clear item: one slot freed per cycle across the table, then the result strobe.
// Insert item: a scan read and check per occupied low slot passed by the free-slot scan,
//   one for the free slot, the home-slot remainder, a read and check per probe, then the
//   result strobe; full ends at scan. Busy is low from the result cycle on; one item at
//   a time, results cannot be stalled. Reset is synchronous: control registers return to
//   their defaults and a clearing pass over every slot runs with busy high.
module open_addressing_hash_insert import oahi_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_op,
   input  logic [KEY_W-1:0]     req_key,
   input  logic                 csr_we,
   input  logic                 csr_index,
   input  logic [SIZE_W-1:0]    csr_wdata,
   output logic                 rsp_valid,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [SLOT_W-1:0]    rsp_slot,
   output logic [PROBES_W-1:0]  rsp_probes
);

   // config registers
   logic [SIZE_W-1:0] table_size_ff;
   logic [MODE_W-1:0] probe_mode_ff;
   logic [SIZE_W-1:0] m_eff;

   // sequencer
   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;      // clearing pass address
   logic              clr_rsp_ff, clr_rsp_in; // clear came from an item, not reset
   logic [CNT_W-1:0]  low_free_ff, low_free_in; // no free slot below this index
   logic [SIZE_W-1:0] used_count_ff, used_count_in;
   logic [KEY_W-1:0]  key_ff;
   logic              key_load;

   // probe walk
   logic [ADDR_W-1:0] addr_ff, addr_in;    // current probe address
   logic [ADDR_W-1:0] step_ff, step_in;    // distance to next probe, mod m
   logic [CNT_W-1:0]  idx_ff, idx_in;      // probe number

   // result registers
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [PROBES_W-1:0] rsp_probes_ff, rsp_probes_in;

   // slot memories
   logic                used_mem [TABLE_DEPTH];
   logic [KEY_W-1:0]    key_mem  [TABLE_DEPTH];
   logic                used_rd_ff;
   logic [ADDR_W-1:0]   mem_raddr;
   logic                mem_we;
   logic [ADDR_W-1:0]   mem_waddr;
   logic                mem_wdata;
   logic                key_we;

   // remainder unit
   logic                div_start;
   logic                div_done;
   logic [ADDR_W-1:0]   div_rem;

   logic accept;

   assign accept = start && (state_ff == S_IDLE);
   assign busy   = (state_ff != S_IDLE);

   // size 0 acts as 1, sizes above the depth saturate
   always_comb begin
      if (table_size_ff == '0) begin
         m_eff = SIZE_W'(1);
      end else if (table_size_ff > SIZE_MAX) begin
         m_eff = SIZE_MAX;
      end else begin
         m_eff = table_size_ff;
      end
   end

   oahi_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (key_ff),
      .divisor   (m_eff),
      .done      (div_done),
      .remainder (div_rem)
   );

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      clr_rsp_in    = clr_rsp_ff;
      low_free_in   = low_free_ff;
      used_count_in = used_count_ff;
      addr_in       = addr_ff;
      step_in       = step_ff;
      idx_in        = idx_ff;
      key_load      = 1'b0;
      rsp_valid_in  = 1'b0;
      rsp_status_in = STATUS_DONE;
      rsp_slot_in   = '0;
      rsp_probes_in = '0;
      mem_raddr     = addr_ff;
      mem_we        = 1'b0;
      mem_waddr     = addr_ff;
      mem_wdata     = 1'b1;
      key_we        = 1'b0;
      div_start     = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = 1'b0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == LAST_ADDR) begin
               low_free_in   = '0;
               used_count_in = '0;
               rsp_valid_in  = clr_rsp_ff;
               state_in      = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               key_load = 1'b1;
               if (req_op == OP_CLEAR) begin
                  clr_in     = '0;
                  clr_rsp_in = 1'b1;
                  state_in   = S_CLEAR;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         // full test: walk the lowest-free pointer up past occupied slots
         S_SCAN: begin
            mem_raddr = low_free_ff[ADDR_W-1:0];
            if (low_free_ff >= CNT_W'(m_eff)) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_FULL;
               state_in      = S_IDLE;
            end else begin
               state_in = S_SCAN_CHK;
            end
         end
         S_SCAN_CHK: begin
            if (used_rd_ff) begin
               low_free_in = low_free_ff + 1'b1;
               state_in    = S_SCAN;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         // home slot ready: set up the first probe and the stride
         S_DIV: begin
            if (div_done) begin
               addr_in = div_rem;
               idx_in  = '0;
               case (probe_mode_ff)
                  MODE_QUAD:   step_in = add2_mod('0, m_eff);
                  MODE_DOUBLE: step_in = add_mod(div_rem, ADDR_W'(1), m_eff);
                  default:     step_in = add_mod('0, ADDR_W'(1), m_eff);
               endcase
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            mem_raddr = addr_ff;
            state_in  = S_PROBE_CHK;
         end
         S_PROBE_CHK: begin
            if (!used_rd_ff) begin
               mem_we        = 1'b1;
               key_we        = 1'b1;
               used_count_in = used_count_ff + 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_slot_in   = SLOT_W'(addr_ff);
               rsp_probes_in = PROBES_W'(idx_ff);
               state_in      = S_IDLE;
            end else if ((idx_ff + 1'b1) == CNT_W'(m_eff)) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_LIMIT;
               rsp_probes_in = PROBES_W'(m_eff);
               state_in      = S_IDLE;
            end else begin
               // quadratic: gap between probes i and i+1 is 2(i+1)
               addr_in = add_mod(addr_ff, step_ff, m_eff);
               if (probe_mode_ff == MODE_QUAD) begin
                  step_in = add2_mod(step_ff, m_eff);
               end
               idx_in   = idx_ff + 1'b1;
               state_in = S_PROBE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         clr_rsp_ff    <= 1'b0;
         low_free_ff   <= '0;
         used_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         table_size_ff <= SIZE_MAX;
         probe_mode_ff <= MODE_LINEAR;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         clr_rsp_ff    <= clr_rsp_in;
         low_free_ff   <= low_free_in;
         used_count_ff <= used_count_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_we) begin
            if (csr_index == CSR_TABLE_SIZE) begin
               table_size_ff <= csr_wdata;
            end else begin
               probe_mode_ff <= csr_wdata[MODE_W-1:0];
            end
         end
      end
   end

   // datapath, no reset
   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      step_ff       <= step_in;
      idx_ff        <= idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_probes_ff <= rsp_probes_in;
      if (key_load) begin
         key_ff <= req_key;
      end
   end

   // used bits: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         used_mem[mem_waddr] <= mem_wdata;
      end
      used_rd_ff <= used_mem[mem_raddr];
   end

   // stored keys
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[addr_ff] <= key_ff;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_slot   = rsp_slot_ff;
   assign rsp_probes = rsp_probes_ff;

endmodule

// ----- rtl/core/oahi_check.sv -----
module oahi_check import oahi_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic                rsp_valid,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [SLOT_W-1:0]   rsp_slot,
   input logic [PROBES_W-1:0] rsp_probes
);

   // an accepted item keeps the block busy next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not raise busy");

   // result shows as the block returns to idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held over two cycles");

   a_fail_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_DONE) |-> (rsp_slot == '0))
      else $error("failed insert reports a slot");

   a_full_probes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_FULL) |-> (rsp_probes == '0))
      else $error("table-full result reports probes");

endmodule

bind open_addressing_hash_insert oahi_check u_oahi_check (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_valid  (rsp_valid),
   .rsp_status (rsp_status),
   .rsp_slot   (rsp_slot),
   .rsp_probes (rsp_probes)
);

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

// Insert / clear testbench for the open-addressing hash table.
// A directed table walks the register extremes and the full, limit and clear cases.
// Random phases then reprogram size and probe mode, mostly with small tables, so
// that the table fills and the full and limit outcomes come up often.
module tb;
   import oahi_pkg::*;

   localparam logic [MODE_W-1:0] MODE_ALIAS = 2'd3;   // unused code, acts as linear
   localparam int RANDOM_ITEMS  = 700;
   localparam int STALL_LIMIT   = 20000;
   localparam int SETTLE_CYCLES = 4200;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic [PROBES_W-1:0] probes;
   } placement_type;

   // one row of the directed table: either a register setting or an item
   typedef struct {
      bit                is_csr;
      logic [SIZE_W-1:0] size_wdata;
      logic [SIZE_W-1:0] mode_wdata;
      logic              op;
      logic [KEY_W-1:0]  key;
      bit                has_fixed;
      placement_type     fixed_res;
   } step_type;

   logic                clock;
   logic                reset     = 1'b1;
   logic                start     = 1'b0;
   logic                busy;
   logic                req_op    = OP_INSERT;
   logic [KEY_W-1:0]    req_key   = '0;
   logic                csr_we    = 1'b0;
   logic                csr_index = CSR_TABLE_SIZE;
   logic [SIZE_W-1:0]   csr_wdata = '0;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [SLOT_W-1:0]   rsp_slot;
   logic [PROBES_W-1:0] rsp_probes;

   // predictor state
   bit                slot_taken [TABLE_DEPTH];
   logic [SIZE_W-1:0] size_reg = SIZE_MAX;
   logic [MODE_W-1:0] mode_reg = MODE_LINEAR;

   placement_type placements_due[$];
   step_type      directed_steps[$];
   placement_type want;

   int bad_results  = 0;
   int results_seen = 0;
   int full_seen    = 0;
   int limit_seen   = 0;
   int inserts_sent = 0;
   int clears_sent  = 0;
   int stall_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   open_addressing_hash_insert u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_op     (req_op),
      .req_key    (req_key),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_valid  (rsp_valid),
      .rsp_status (rsp_status),
      .rsp_slot   (rsp_slot),
      .rsp_probes (rsp_probes)
   );

   // size register as the block uses it: zero acts as one, saturates at the depth
   function automatic longint unsigned live_slots(input logic [SIZE_W-1:0] size_w);
      if (size_w == '0) return 1;
      if (size_w > SIZE_MAX) return TABLE_DEPTH;
      return size_w;
   endfunction

   // outcome of one item; updates the slot map
   function automatic placement_type place_key(input logic op, input logic [KEY_W-1:0] key);
      placement_type res;
      longint unsigned m, k, home, i, a;
      bit room;
      res = '0;
      res.status = STATUS_DONE;
      if (op == OP_CLEAR) begin
         foreach (slot_taken[j]) slot_taken[j] = 1'b0;
         return res;
      end
      m = live_slots(size_reg);
      k = key;
      home = k % m;
      room = 1'b0;
      // full test looks at slots 0..m-1 only, not at the probe reach
      for (a = 0; a < m; a++) begin
         if (!slot_taken[a]) room = 1'b1;
      end
      if (!room) begin
         res.status = STATUS_FULL;
         return res;
      end
      for (i = 0; i < m; i++) begin
         case (mode_reg)
            MODE_QUAD:   a = (home + i + i * i) % m;
            MODE_DOUBLE: a = (k + i * (k + 1)) % m;
            default:     a = (home + i) % m;
         endcase
         if (!slot_taken[a]) begin
            slot_taken[a] = 1'b1;
            res.slot   = SLOT_W'(a);
            res.probes = PROBES_W'(i);
            return res;
         end
      end
      // every probe hit a used slot: probes reports m
      res.status = STATUS_LIMIT;
      res.probes = PROBES_W'(m);
      return res;
   endfunction

   function automatic void add_csr(input logic [SIZE_W-1:0] size_w,
                                   input logic [SIZE_W-1:0] mode_w);
      step_type s;
      s = '{1'b1, size_w, mode_w, OP_INSERT, '0, 1'b0, '0};
      directed_steps.push_back(s);
   endfunction

   function automatic void add_item(input logic op, input logic [KEY_W-1:0] key);
      step_type s;
      s = '{1'b0, '0, '0, op, key, 1'b0, '0};
      directed_steps.push_back(s);
   endfunction

   function automatic void add_checked(input logic op, input logic [KEY_W-1:0] key,
                                       input logic [STATUS_W-1:0] status,
                                       input logic [SLOT_W-1:0] slot,
                                       input logic [PROBES_W-1:0] probes);
      step_type s;
      s = '{1'b0, '0, '0, op, key, 1'b1, '{status, slot, probes}};
      directed_steps.push_back(s);
   endfunction

   // present one item after a gap, hold it until taken; start stays high afterwards
   task automatic issue(input logic op, input logic [KEY_W-1:0] key, input int gap,
                        input bit has_fixed, input placement_type fixed_res);
      placement_type r;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_op  <= op;
      req_key <= key;
      start   <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      r = place_key(op, key);
      placements_due.push_back(has_fixed ? fixed_res : r);
      if (op == OP_CLEAR) clears_sent++;
      else inserts_sent++;
   endtask

   // stop sending and wait until the block is idle with nothing outstanding
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (placements_due.size() != 0 || busy !== 1'b0);
   endtask

   // both registers, back to back; only called with the block idle
   task automatic write_regs(input logic [SIZE_W-1:0] size_w,
                             input logic [SIZE_W-1:0] mode_w);
      csr_we    <= 1'b1;
      csr_index <= CSR_TABLE_SIZE;
      csr_wdata <= size_w;
      @(posedge clock);
      size_reg = size_w;
      csr_index <= CSR_PROBE_MODE;
      csr_wdata <= mode_w;
      @(posedge clock);
      mode_reg = mode_w[MODE_W-1:0];
      csr_we <= 1'b0;
   endtask

   // result checker: each strobe pops the oldest outstanding expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (placements_due.size() == 0) begin
            bad_results++;
            if (bad_results <= 10)
               $display("%0t: result with no item outstanding: status %0d slot %0d probes %0d",
                        $realtime, rsp_status, rsp_slot, rsp_probes);
         end else begin
            want = placements_due.pop_front();
            results_seen++;
            if (want.status == STATUS_FULL) full_seen++;
            if (want.status == STATUS_LIMIT) limit_seen++;
            if (rsp_status !== want.status || rsp_slot !== want.slot ||
                rsp_probes !== want.probes) begin
               bad_results++;
               if (bad_results <= 10)
                  $display("%0t: mismatch status %0d/%0d slot %0d/%0d probes %0d/%0d (exp/act)",
                           $realtime, want.status, rsp_status, want.slot, rsp_slot,
                           want.probes, rsp_probes);
            end
         end
      end
   end

   // watchdog: cycles with neither an item taken nor a result strobe
   always @(posedge clock) begin
      if ((start && busy === 1'b0) || rsp_valid === 1'b1) begin
         stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      int random_items;
      int phases;
      int n;
      int gap;
      bit gapless;
      logic [SIZE_W-1:0] size_w;
      logic [SIZE_W-1:0] mode_w;
      logic [3:0] modes_used;
      longint unsigned m;
      logic [KEY_W-1:0] key;
      logic op;

      random_items = 0;
      phases = 0;
      modes_used = '0;

      // directed table; reset values first (1024 slots, linear)
      add_checked(OP_INSERT, 31'd0, STATUS_DONE, 10'd0, 11'd0);
      add_checked(OP_INSERT, 31'h7FFF_FFFF, STATUS_DONE, 10'd1023, 11'd0);
      add_checked(OP_INSERT, 31'd1024, STATUS_DONE, 10'd1, 11'd1);   // home 0 taken
      add_checked(OP_CLEAR, 31'h7FFF_FFFF, STATUS_DONE, 10'd0, 11'd0);
      // size zero behaves as one slot
      add_csr(11'd0, {9'd0, MODE_LINEAR});
      add_checked(OP_INSERT, 31'd5, STATUS_DONE, 10'd0, 11'd0);
      add_checked(OP_INSERT, 31'd7, STATUS_FULL, 10'd0, 11'd0);
      // oversize saturates to the depth; mode upper bits ignored
      add_csr(11'h7FF, {9'h1FF, MODE_LINEAR});
      add_checked(OP_INSERT, 31'd1023, STATUS_DONE, 10'd1023, 11'd0);
      add_item(OP_INSERT, 31'h2AAA_AAAA);
      add_checked(OP_CLEAR, 31'd0, STATUS_DONE, 10'd0, 11'd0);
      // quadratic on 4 slots only reaches even offsets from home
      add_csr(11'd4, {9'd0, MODE_QUAD});
      add_checked(OP_INSERT, 31'd0, STATUS_DONE, 10'd0, 11'd0);
      add_checked(OP_INSERT, 31'd4, STATUS_DONE, 10'd2, 11'd1);
      add_checked(OP_INSERT, 31'd8, STATUS_LIMIT, 10'd0, 11'd4);
      add_checked(OP_INSERT, 31'd1, STATUS_DONE, 10'd1, 11'd0);
      add_checked(OP_INSERT, 31'd3, STATUS_DONE, 10'd3, 11'd0);
      add_checked(OP_INSERT, 31'd9, STATUS_FULL, 10'd0, 11'd0);
      add_checked(OP_CLEAR, 31'd0, STATUS_DONE, 10'd0, 11'd0);
      // double hashing on 6 slots; key 3 steps by 4 and cycles over 1,3,5
      add_csr(11'd6, {9'd0, MODE_DOUBLE});
      add_item(OP_INSERT, 31'd1);
      add_item(OP_INSERT, 31'd7);
      add_item(OP_INSERT, 31'd1);
      add_item(OP_INSERT, 31'd3);
      // mode code 3 falls back to linear
      add_csr(11'd6, {9'h155, MODE_ALIAS});
      add_item(OP_INSERT, 31'd5);
      add_csr(SIZE_MAX, {9'd0, MODE_LINEAR});
      add_item(OP_INSERT, 31'h5555_5555);
      add_item(OP_CLEAR, 31'h5555_5555);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_steps[i]) begin
         if (directed_steps[i].is_csr) begin
            drain();
            write_regs(directed_steps[i].size_wdata, directed_steps[i].mode_wdata);
            modes_used[directed_steps[i].mode_wdata[MODE_W-1:0]] = 1'b1;
         end else begin
            issue(directed_steps[i].op, directed_steps[i].key, $urandom_range(0, 11),
                  directed_steps[i].has_fixed, directed_steps[i].fixed_res);
         end
      end

      // random phases: new setting, optional clear, then enough inserts to fill small tables
      while (random_items < RANDOM_ITEMS) begin
         phases++;
         gapless = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 19))
            0:       size_w = 11'd0;
            1:       size_w = 11'd1;
            2:       size_w = 11'd2;
            3:       size_w = SIZE_MAX;
            4:       size_w = SIZE_W'($urandom_range(TABLE_DEPTH + 1, 2047));
            5:       size_w = SIZE_W'($urandom_range(65, TABLE_DEPTH - 1));
            default: size_w = SIZE_W'($urandom_range(3, 64));
         endcase
         mode_w = SIZE_W'($urandom());
         mode_w[MODE_W-1:0] = MODE_W'($urandom_range(0, 3));
         drain();
         write_regs(size_w, mode_w);
         modes_used[mode_w[MODE_W-1:0]] = 1'b1;
         m = live_slots(size_w);
         // large tables get few inserts to keep scan and probe time down
         n = (m <= 64) ? int'(m) + $urandom_range(2, 8) : $urandom_range(10, 40);
         if ($urandom_range(0, 1) == 0) begin
            issue(OP_CLEAR, KEY_W'($urandom()), gapless ? 0 : $urandom_range(0, 11),
                  1'b0, '0);
            random_items++;
         end
         for (int j = 0; j < n; j++) begin
            op = ($urandom_range(0, 24) == 0) ? OP_CLEAR : OP_INSERT;
            case ($urandom_range(0, 5))
               0:       key = 31'h7FFF_FFFF - KEY_W'($urandom_range(0, 3));
               1:       key = KEY_W'($urandom_range(0, 63));
               2:       key = KEY_W'(m * $urandom_range(0, 1000));   // same home slot
               default: key = KEY_W'($urandom());
            endcase
            gap = gapless ? 0 : $urandom_range(0, 11);
            issue(op, key, gap, 1'b0, '0);
            random_items++;
         end
         // now and then hold off until every result is back
         if ($urandom_range(0, 3) == 0) drain();
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("%0d items (%0d inserts, %0d clears), %0d results checked, %0d mismatches",
               inserts_sent + clears_sent, inserts_sent, clears_sent, results_seen,
               bad_results);
      $display("%0d random settings, mode codes seen %b, table full %0d, probe limit %0d",
               phases, modes_used, full_seen, limit_seen);
      if (bad_results == 0 && placements_due.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
